// ===== rtl/core/glmm_pkg.sv =====
// Package for the grid local maximum marker.
// Holds shared constants and the item control type; no dependencies.
package glmm_pkg;

  localparam int MAX_GRID   = 1024;
  localparam int VALUE_BITS = 8;
  localparam int CFG_BITS   = 11;
  localparam int GRID_RESET = 8;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } glmm_tok_t;

  localparam int TOK_BITS = $bits(glmm_tok_t);

endpackage

// ===== rtl/core/glmm_if.sv =====
// Valid/ready channel interfaces for the pixel input and the marked cell output.
// Depends on glmm_pkg for default widths.
interface glmm_in_if #(
  parameter int VALUE_BITS = glmm_pkg::VALUE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] pixel_value;
  logic                  drain;

  modport source (output valid, pixel_value, drain, input ready);
  modport sink (input valid, pixel_value, drain, output ready);
endinterface

interface glmm_out_if #(
  parameter int VALUE_BITS = glmm_pkg::VALUE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] cell_value;
  logic                  is_cavity;
  logic                  last_cell;

  modport source (output valid, cell_value, is_cavity, last_cell, input ready);
  modport sink (input valid, cell_value, is_cavity, last_cell, output ready);
endinterface

// ===== rtl/core/glmm_front.sv =====
// Front end: grid size register, raster position tracking and per-item classification.
// Depends on glmm_pkg and glmm_in_if; pushes tokens into the item queue.
module glmm_front #(
  parameter int MAX_GRID   = glmm_pkg::MAX_GRID,
  parameter int VALUE_BITS = glmm_pkg::VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [glmm_pkg::CFG_BITS-1:0] cfg_wdata_i,
  glmm_in_if.sink                       pix_i,
  input  logic                          full_i,
  output logic                          push_o,
  output glmm_pkg::glmm_tok_t           tok_o,
  output logic [$clog2(MAX_GRID)-1:0]   col_o,
  output logic [VALUE_BITS-1:0]         pix_o
);

  localparam int CW   = $clog2(MAX_GRID);
  localparam int RW   = $clog2(MAX_GRID + 3);
  localparam int RstN = (glmm_pkg::GRID_RESET > MAX_GRID) ? MAX_GRID : glmm_pkg::GRID_RESET;

  logic [RW-1:0] n_q, n_d;
  logic [RW-1:0] ir_q, ir_d;
  logic [CW-1:0] ic_q, ic_d;
  logic [RW-1:0] ic_x, ic_n, qr, qc;
  logic          emit, interior, last;

  assign pix_i.ready = !full_i;
  assign push_o      = pix_i.valid && !full_i;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      n_d = RW'(1);
    end else if (32'(cfg_wdata_i) > MAX_GRID) begin
      n_d = RW'(MAX_GRID);
    end else begin
      n_d = RW'(cfg_wdata_i);
    end
  end

  always_comb begin
    ic_x = RW'(ic_q);
    if (ic_q != '0) begin
      emit = ir_q >= RW'(1);
      qr   = ir_q - RW'(1);
      qc   = ic_x - RW'(1);
    end else begin
      emit = ir_q >= RW'(2);
      qr   = ir_q - RW'(2);
      qc   = n_q - RW'(1);
    end
    emit     = emit && (qr < n_q);
    interior = (qr >= RW'(1)) && (qc >= RW'(1)) &&
               (({1'b0, qr} + (RW+1)'(2)) <= {1'b0, n_q}) &&
               (({1'b0, qc} + (RW+1)'(2)) <= {1'b0, n_q});
    last     = (qr == n_q - RW'(1)) && (qc == n_q - RW'(1));

    ic_n = ic_x + RW'(1);
    ir_d = ir_q;
    ic_d = CW'(ic_n);
    if (ic_n >= n_q) begin
      ic_d = '0;
      ir_d = ir_q + RW'(1);
    end
    if (ir_d > n_q + RW'(1)) begin
      ir_d = n_q + RW'(1);
    end
    if (emit && last) begin
      ir_d = '0;
      ic_d = '0;
    end
  end

  assign tok_o = '{emit: emit, interior: interior, last: last};
  assign col_o = ic_q;
  assign pix_o = (pix_i.drain || (ir_q >= n_q)) ? '0 : pix_i.pixel_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q  <= RW'(RstN);
      ir_q <= '0;
      ic_q <= '0;
    end else if (cfg_we_i) begin
      n_q  <= n_d;
      ir_q <= '0;
      ic_q <= '0;
    end else if (push_o) begin
      ir_q <= ir_d;
      ic_q <= ic_d;
    end
  end

  a_col_in_grid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    RW'(ic_q) < n_q)
    else $error("Column position is outside the grid.");

  a_row_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ir_q} <= {1'b0, n_q} + (RW+1)'(1))
    else $error("Row position ran past the drain limit.");

  a_last_wraps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && tok_o.emit && tok_o.last |=> ir_q == '0 && ic_q == '0)
    else $error("Position did not return to the grid start after the last cell.");

endmodule

// ===== rtl/core/glmm_queue.sv =====
// Short item queue between the front end and the back end.
// Depends on glmm_pkg for the default depth.
module glmm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = glmm_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [CNW-1:0]   cnt_q;

  assign full_o  = cnt_q == CNW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNW'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("Item pushed into a full queue.");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("Item popped from an empty queue.");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNW'(DEPTH))
    else $error("Queue fill count exceeds its depth.");

endmodule

// ===== rtl/core/glmm_back.sv =====
// Back end: line stores, 3x3 window, four-neighbour compare and output register.
// Depends on glmm_pkg and glmm_out_if; pops tokens from the item queue.
module glmm_back #(
  parameter int MAX_GRID   = glmm_pkg::MAX_GRID,
  parameter int VALUE_BITS = glmm_pkg::VALUE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  glmm_pkg::glmm_tok_t         tok_i,
  input  logic [$clog2(MAX_GRID)-1:0] col_i,
  input  logic [VALUE_BITS-1:0]       pix_i,
  output logic                        pop_o,
  glmm_out_if.source                  res_o
);

  localparam int CW = $clog2(MAX_GRID);

  logic [VALUE_BITS-1:0] upper_mem [MAX_GRID];
  logic [VALUE_BITS-1:0] middle_mem [MAX_GRID];
  logic [VALUE_BITS-1:0] win_q [3][3];

  logic                  adv, a_load;
  logic                  a_vld_q, b_vld_q, hz_q;
  glmm_pkg::glmm_tok_t   a_tok_q, b_tok_q;
  logic [CW-1:0]         a_col_q, b_col_q;
  logic [VALUE_BITS-1:0] a_pix_q, b_pix_q;
  logic [VALUE_BITS-1:0] rd_top_q, rd_mid_q, fw_top_q, fw_mid_q;
  logic [VALUE_BITS-1:0] b_top, b_mid;
  logic                  cav;
  logic                  o_vld_q;
  logic [VALUE_BITS-1:0] o_val_q;
  logic                  o_cav_q, o_last_q;

  assign adv    = !o_vld_q || res_o.ready;
  assign a_load = !a_vld_q || adv;
  assign pop_o  = a_load && !empty_i;

  // A cell written by the item leaving the window stage is forwarded when the
  // next item reads the same column in the same cycle.
  assign b_top = hz_q ? fw_top_q : rd_top_q;
  assign b_mid = hz_q ? fw_mid_q : rd_mid_q;

  assign cav = b_tok_q.interior &&
               (win_q[1][2] > win_q[0][2]) && (win_q[1][2] > win_q[2][2]) &&
               (win_q[1][2] > win_q[1][1]) && (win_q[1][2] > b_mid);

  always_ff @(posedge clk_i) begin
    if (adv && b_vld_q) begin
      upper_mem[b_col_q]  <= b_mid;
      middle_mem[b_col_q] <= b_pix_q;
    end
    if (adv && a_vld_q) begin
      rd_top_q <= upper_mem[a_col_q];
      rd_mid_q <= middle_mem[a_col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_tok_q <= tok_i;
      a_col_q <= col_i;
      a_pix_q <= pix_i;
    end
    if (adv) begin
      b_tok_q  <= a_tok_q;
      b_col_q  <= a_col_q;
      b_pix_q  <= a_pix_q;
      fw_top_q <= b_mid;
      fw_mid_q <= b_pix_q;
      o_val_q  <= win_q[1][2];
      o_cav_q  <= cav;
      o_last_q <= b_tok_q.last;
    end
    if (adv && b_vld_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= b_top;
      win_q[1][2] <= b_mid;
      win_q[2][2] <= b_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      hz_q    <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_load) begin
        a_vld_q <= !empty_i;
      end
      if (adv) begin
        b_vld_q <= a_vld_q;
        hz_q    <= a_vld_q && b_vld_q && (a_col_q == b_col_q);
        o_vld_q <= b_vld_q && b_tok_q.emit;
      end
    end
  end

  assign res_o.valid      = o_vld_q;
  assign res_o.cell_value = o_val_q;
  assign res_o.is_cavity  = o_cav_q;
  assign res_o.last_cell  = o_last_q;

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv && a_vld_q |=> $stable(b_vld_q) && $stable(a_vld_q))
    else $error("Back end stages moved while the output was stalled.");

  a_forward_same_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hz_q |-> b_vld_q)
    else $error("Forwarding flagged without an item in the window stage.");

  a_result_from_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(o_vld_q) |-> $past(b_vld_q) && $past(b_tok_q.emit))
    else $error("Result shown without an emitting item behind it.");

endmodule

// ===== rtl/core/grid_local_maximum_marker_top.sv =====
// Grid local maximum marker: marks interior cells greater than their four neighbours.
// Depends on glmm_pkg, glmm_if, glmm_front, glmm_queue and glmm_back.
//
// Usage: pixel items of a square grid arrive in raster order on pix_i, one per
// cycle at full rate. A drain item carries no pixel and only advances the
// stream. Each cell leaves on res_o with its value, a mark flag and a flag on
// the final cell. A cell leaves once the item one row and one cell after it has
// been taken, so after the last pixel the host sends grid size plus one drain
// items. The grid size is written through cfg_we_i and cfg_wdata_i while the
// block is idle; a write restarts the stream at the first cell.
// Throughput is one item per cycle while the queue is not full; the front end
// classifies an item in the cycle it is taken, and a four entry queue, a line
// store read stage, a window stage and the output register follow before a
// result shows on res_o. A stalled receiver holds the output register; the
// queue keeps taking items until it is full, and then pix_i.ready falls.
// Reset sets the grid size to 8 and the stream to the first cell. The line
// stores get no clearing pass, since a cell is never marked or shown from a
// line store entry that the current grid has not written.
module grid_local_maximum_marker_top #(
  parameter int MAX_GRID   = glmm_pkg::MAX_GRID,
  parameter int VALUE_BITS = glmm_pkg::VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [glmm_pkg::CFG_BITS-1:0] cfg_wdata_i,
  glmm_in_if.sink                       pix_i,
  glmm_out_if.source                    res_o
);

  localparam int CW = $clog2(MAX_GRID);
  localparam int QW = glmm_pkg::TOK_BITS + CW + VALUE_BITS;

  logic                  push, pop, full, empty;
  glmm_pkg::glmm_tok_t   f_tok, b_tok;
  logic [CW-1:0]         f_col, b_col;
  logic [VALUE_BITS-1:0] f_pix, b_pix;
  logic [QW-1:0]         q_out;

  glmm_front #(
    .MAX_GRID   (MAX_GRID),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_i),
    .full_i      (full),
    .push_o      (push),
    .tok_o       (f_tok),
    .col_o       (f_col),
    .pix_o       (f_pix)
  );

  glmm_queue #(
    .WIDTH (QW),
    .DEPTH (glmm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_tok, f_col, f_pix}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (empty)
  );

  assign {b_tok, b_col, b_pix} = q_out;

  glmm_back #(
    .MAX_GRID   (MAX_GRID),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .tok_i   (b_tok),
    .col_i   (b_col),
    .pix_i   (b_pix),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the grid local maximum marker: sends raster grids, flush items and
// grid size writes, and checks every emitted cell against a line store predictor.
// Depends on glmm_pkg, glmm_if and grid_local_maximum_marker_top.
module tb_top;

  localparam int LIMIT_NS      = 2000000;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;

  typedef logic [glmm_pkg::VALUE_BITS-1:0] value_t;
  typedef logic [glmm_pkg::CFG_BITS-1:0]   size_word_t;

  typedef struct packed {
    value_t value;
    logic   cavity;
    logic   last;
  } marked_cell_t;

  class cavity_scoreboard;
    value_t upper_row [glmm_pkg::MAX_GRID];
    value_t middle_row [glmm_pkg::MAX_GRID];
    value_t win [3][3];
    int size_eff;
    int in_row;
    int in_col;
    int errors;
    marked_cell_t expected_cells [$];

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      size_eff = glmm_pkg::GRID_RESET;
      in_row   = 0;
      in_col   = 0;
      errors   = 0;
    endfunction

    function void set_size(size_word_t raw);
      if (raw == 0) begin
        size_eff = 1;
      end else if (raw > glmm_pkg::MAX_GRID) begin
        size_eff = glmm_pkg::MAX_GRID;
      end else begin
        size_eff = int'(raw);
      end
      in_row = 0;
      in_col = 0;
    endfunction

    function void note_item(value_t v, logic d);
      int n, ir, ic, qr, qc;
      value_t px, above, centre;
      bit emit;
      marked_cell_t entry;
      n  = size_eff;
      ir = in_row;
      ic = in_col;
      px = (d || ir >= n) ? '0 : v;
      if (ic >= n) ic = 0;
      above  = upper_row[ic];
      centre = middle_row[ic];
      upper_row[ic]  = centre;
      middle_row[ic] = px;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = above;
      win[1][2] = centre;
      win[2][2] = px;
      // The emitted cell trails the incoming item by one row and one cell.
      emit = 1'b0;
      qr   = 0;
      qc   = 0;
      if (ic >= 1) begin
        if (ir >= 1) begin
          emit = 1'b1;
          qr   = ir - 1;
          qc   = ic - 1;
        end
      end else if (ir >= 2) begin
        emit = 1'b1;
        qr   = ir - 2;
        qc   = n - 1;
      end
      if (qr >= n) emit = 1'b0;
      ic++;
      if (ic >= n) begin
        ic = 0;
        ir++;
      end
      if (ir > n + 1) ir = n + 1;
      if (emit) begin
        entry.value  = win[1][1];
        entry.cavity = qr >= 1 && qc >= 1 && qr + 2 <= n && qc + 2 <= n &&
                       win[1][1] > win[0][1] && win[1][1] > win[2][1] &&
                       win[1][1] > win[1][0] && win[1][1] > win[1][2];
        entry.last   = (qr == n - 1) && (qc == n - 1);
        expected_cells = {expected_cells, entry};
        if (entry.last) begin
          ir = 0;
          ic = 0;
        end
      end
      in_row = ir;
      in_col = ic;
    endfunction

    function void check_cell(value_t v, logic cav, logic last);
      marked_cell_t want;
      if (expected_cells.size() == 0) begin
        $error("unexpected cell: cell_value %0d is_cavity %0b last_cell %0b", v, cav, last);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (v !== want.value) begin
          $error("cell_value: expected %0d, actual %0d", want.value, v);
          errors++;
        end
        if (cav !== want.cavity) begin
          $error("is_cavity: expected %0b, actual %0b", want.cavity, cav);
          errors++;
        end
        if (last !== want.last) begin
          $error("last_cell: expected %0b, actual %0b", want.last, last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  size_word_t       cfg_wdata;
  int               send_gap_pct;
  int               recv_gap_pct;
  int               hold_cycles;
  cavity_scoreboard sb;

  glmm_in_if  pix ();
  glmm_out_if res ();

  grid_local_maximum_marker_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix),
    .res_o       (res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (res.valid && res.ready) sb.check_cell(res.cell_value, res.is_cavity, res.last_cell);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res.ready   <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  task automatic send_item(input value_t v, input logic d);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= v;
    pix.drain       <= d;
    do @(posedge clk); while (!pix.ready);
    sb.note_item(v, d);
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input size_word_t raw);
    cfg_we    <= 1'b1;
    cfg_wdata <= raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_size(raw);
  endtask

  task automatic send_grid(input int n, input int limit, input int top, input int pause_at);
    int k;
    for (k = 0; k < n * n && k < limit; k++) begin
      if (k == pause_at) wait_idle();
      send_item(value_t'($urandom_range(top)), $urandom_range(15) == 0);
    end
    if (limit >= n * n) begin
      for (k = 0; k <= n; k++) send_item(value_t'($urandom_range(255)), $urandom_range(3) != 0);
    end
  endtask

  task automatic run_directed();
    logic [glmm_pkg::VALUE_BITS:0] row_seq [19];
    // Bit 8 marks a drain item; the drain in the first row carries an all-ones value.
    row_seq = '{9'd0, 9'd200, 9'd255, 9'h1FF, 9'd17, 9'd1, 9'd254, 9'd3,
                9'd254, 9'd255, 9'd254, 9'd10, 9'd5, 9'd6, 9'd70, 9'd255,
                9'd1, 9'd254, 9'd0};
    foreach (row_seq[i]) begin
      send_item(row_seq[i][glmm_pkg::VALUE_BITS-1:0], row_seq[i][glmm_pkg::VALUE_BITS]);
    end
    wait_idle();
    write_size('0);
    send_item(8'hFF, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h55, 1'b1);
  endtask

  task automatic run_random();
    int phase, g, grids, n, limit, raw;
    for (phase = 0; phase < 9; phase++) begin
      if (phase < 3) begin
        send_gap_pct = 16;
        recv_gap_pct = 64;
      end else if (phase < 6) begin
        send_gap_pct = 64;
        recv_gap_pct = 16;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      case ($urandom_range(7))
        0: raw = 0;
        1: raw = 1;
        2: raw = 2;
        default: raw = $urandom_range(3, 7);
      endcase
      if (phase == 6) raw = 7;
      wait_idle();
      write_size(size_word_t'(raw));
      n = sb.size_eff;
      if (phase == 6) hold_cycles = HOLD_CYCLES;
      grids = $urandom_range(1, 2);
      for (g = 0; g < grids; g++) begin
        limit = n * n;
        if (g == grids - 1 && n > 1 && $urandom_range(7) == 0) limit = $urandom_range(1, n * n - 1);
        send_grid(n, limit, $urandom_range(1) ? 255 : 3,
                  (phase == 1 && g == 0) ? n * n / 2 : -1);
      end
      if (phase == 4) begin
        wait_idle();
        write_size('1);
        send_grid(sb.size_eff, 24, 255, -1);
      end
    end
  endtask

  initial begin
    sb              = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    pix.valid       = 1'b0;
    pix.pixel_value = '0;
    pix.drain       = 1'b0;
    res.ready       = 1'b0;
    send_gap_pct    = 16;
    recv_gap_pct    = 64;
    hold_cycles     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    wait_idle();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
